/* design/bwc_pkg.sv */
package bwc_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_MINTERM       = 3'd0;
	localparam logic [2:0] REG_A_SHIFT       = 3'd1;
	localparam logic [2:0] REG_B_SHIFT       = 3'd2;
	localparam logic [2:0] REG_FIRST_MASK    = 3'd3;
	localparam logic [2:0] REG_LAST_MASK     = 3'd4;
	localparam logic [2:0] REG_FILL_SELECT   = 3'd5;
	localparam logic [2:0] REG_REVERSE_ORDER = 3'd6;
	localparam logic [2:0] REG_CARRY_START   = 3'd7;

	// Fill modes; the remaining code behaves as no fill.
	localparam logic [1:0] FILL_NONE      = 2'd0;
	localparam logic [1:0] FILL_INCLUSIVE = 2'd1;
	localparam logic [1:0] FILL_EXCLUSIVE = 2'd2;

	localparam int WORD_W = 16;

	typedef struct packed {
		logic [WORD_W-1:0] a_word;
		logic [WORD_W-1:0] b_word;
		logic [WORD_W-1:0] c_word;
		logic              line_first;
		logic              line_last;
		logic              blit_begin;
	} bwc_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] d_word;
		logic              all_zero;
	} bwc_out_t;

	typedef struct packed {
		logic [7:0]        minterm;
		logic [3:0]        a_shift;
		logic [3:0]        b_shift;
		logic [WORD_W-1:0] first_mask;
		logic [WORD_W-1:0] last_mask;
		logic [1:0]        fill_select;
		logic              reverse_order;
		logic              carry_start;
	} bwc_cfg_t;

	// Line state carried from one word to the next.
	typedef struct packed {
		logic [WORD_W-1:0] prev_a;
		logic [WORD_W-1:0] prev_b;
		logic              line_carry;
		logic              zero_flag;
	} bwc_state_t;

endpackage

/* design/bwc_word_logic.sv */
module bwc_word_logic import bwc_pkg::*; (
	input  bwc_cfg_t   cfg,
	input  bwc_in_t    item,
	input  bwc_state_t state,
	output bwc_out_t   result,
	output bwc_state_t state_next
);

	logic [WORD_W-1:0] prev_a;
	logic [WORD_W-1:0] prev_b;
	logic              carry_in;
	logic              zero_in;
	logic [WORD_W-1:0] a_masked;
	logic [WORD_W-1:0] a_shifted;
	logic [WORD_W-1:0] b_shifted;
	logic [WORD_W-1:0] logic_word;
	logic [WORD_W-1:0] fill_word;
	logic [WORD_W-1:0] d_word;
	logic [WORD_W-1:0] carry_before;
	logic              fill_on;
	logic              fill_incl;

	// Funnel shift of the current word with the previous word of the line.
	function automatic logic [WORD_W-1:0] shift_pair(
		input logic [WORD_W-1:0] prev,
		input logic [WORD_W-1:0] cur,
		input logic [3:0]        s,
		input logic              desc
	);
		logic [2*WORD_W-1:0] wide;
		begin
			if (desc) begin
				wide = {cur, prev} << s;
				shift_pair = wide[2*WORD_W-1:WORD_W];
			end else begin
				wide = {prev, cur} >> s;
				shift_pair = wide[WORD_W-1:0];
			end
		end
	endfunction

	// A first word of a line starts from cleared history and the start carry.
	always_comb begin
		prev_a   = item.line_first ? '0 : state.prev_a;
		prev_b   = item.line_first ? '0 : state.prev_b;
		carry_in = item.line_first ? cfg.carry_start : state.line_carry;
		zero_in  = item.blit_begin ? 1'b1 : state.zero_flag;
	end

	// Edge masks on source A.
	always_comb begin
		a_masked = item.a_word;
		if (item.line_first) begin
			a_masked = a_masked & cfg.first_mask;
		end
		if (item.line_last) begin
			a_masked = a_masked & cfg.last_mask;
		end
	end

	assign a_shifted = shift_pair(prev_a, a_masked, cfg.a_shift, cfg.reverse_order);
	assign b_shifted = shift_pair(prev_b, item.b_word, cfg.b_shift, cfg.reverse_order);

	// Minterm lookup: each bit of A, B and C indexes the truth table.
	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			logic_word[i] = cfg.minterm[{a_shifted[i], b_shifted[i], item.c_word[i]}];
		end
	end

	// The carry ahead of each bit is the incoming line carry XOR the parity of the
	// bits already scanned: higher bits when ascending, lower when descending.
	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			logic [WORD_W-1:0] seen;
			seen = '0;
			for (int j = 0; j < WORD_W; j++) begin
				if (cfg.reverse_order) begin
					seen[j] = (j < i) ? logic_word[j] : 1'b0;
				end else begin
					seen[j] = (j > i) ? logic_word[j] : 1'b0;
				end
			end
			carry_before[i] = carry_in ^ (^seen);
		end
	end

	assign fill_on   = (cfg.fill_select == FILL_INCLUSIVE) ||
	                   (cfg.fill_select == FILL_EXCLUSIVE);
	assign fill_incl = (cfg.fill_select == FILL_INCLUSIVE);
	assign fill_word = fill_incl ? (carry_before | logic_word) : (carry_before ^ logic_word);
	assign d_word    = fill_on ? fill_word : logic_word;

	// Outgoing word and the state left for the next word.
	always_comb begin
		result.d_word         = d_word;
		result.all_zero       = zero_in & (d_word == '0);
		state_next.prev_a     = a_masked;
		state_next.prev_b     = item.b_word;
		state_next.line_carry = fill_on ? (carry_in ^ (^logic_word)) : carry_in;
		state_next.zero_flag  = zero_in & (d_word == '0);
	end

endmodule

/* design/blit_word_combiner_unit.sv */
// Blitter word combiner: each accepted word carries one word of sources A, B
// and C plus line and blit marks, and yields one destination word with a
// running all-zero flag. The unit takes one word per clock while the output
// register is free or drains; each word is captured in an input
// register, then masking, the two funnel shifts, the minterm lookup and the
// area fill are evaluated in one pass into the output register, where the
// line state (previous A and B words, fill carry, zero flag) is updated too.
// The output register lets a new word be accepted while a result waits.
// Configuration writes are always ready and must be made while no word is
// in flight.
module blit_word_combiner_unit import bwc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  bwc_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output bwc_out_t   out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	bwc_cfg_t   cfg_q;
	bwc_in_t    item_s1;
	logic       valid_s1;
	bwc_out_t   out_data_q;
	logic       out_valid_q;
	bwc_state_t state_q;
	bwc_state_t state_next;
	bwc_out_t   result;
	logic       advance;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.minterm       <= '0;
			cfg_q.a_shift       <= '0;
			cfg_q.b_shift       <= '0;
			cfg_q.first_mask    <= '1;
			cfg_q.last_mask     <= '1;
			cfg_q.fill_select   <= FILL_NONE;
			cfg_q.reverse_order <= 1'b0;
			cfg_q.carry_start   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MINTERM:       cfg_q.minterm       <= cfg_data[7:0];
				REG_A_SHIFT:       cfg_q.a_shift       <= cfg_data[3:0];
				REG_B_SHIFT:       cfg_q.b_shift       <= cfg_data[3:0];
				REG_FIRST_MASK:    cfg_q.first_mask    <= cfg_data;
				REG_LAST_MASK:     cfg_q.last_mask     <= cfg_data;
				REG_FILL_SELECT:   cfg_q.fill_select   <= cfg_data[1:0];
				REG_REVERSE_ORDER: cfg_q.reverse_order <= cfg_data[0];
				REG_CARRY_START:   cfg_q.carry_start   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The input stage moves on whenever the output register is free or drains.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	bwc_word_logic u_word_logic (
		.cfg        (cfg_q),
		.item       (item_s1),
		.state      (state_q),
		.result     (result),
		.state_next (state_next)
	);

	// Line state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prev_a     <= '0;
			state_q.prev_b     <= '0;
			state_q.line_carry <= 1'b0;
			state_q.zero_flag  <= 1'b1;
			out_valid_q        <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// An empty input stage always takes a word.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	// A stalled input stage keeps its word.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stalled word dropped from input stage");

	// The stored zero flag matches the flag just delivered.
	a_zero_track: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 |=> state_q.zero_flag == out_data_q.all_zero)
		else $error("zero flag out of step with result");

	// A nonzero destination word can never report all zero.
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q.d_word != '0) |-> !out_data_q.all_zero)
		else $error("all_zero set on nonzero word");

	// Without fill, the carry only changes at the start of a line.
	a_carry_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && !item_s1.line_first &&
		(cfg_q.fill_select != FILL_INCLUSIVE) && (cfg_q.fill_select != FILL_EXCLUSIVE)
		|=> state_q.line_carry == $past(state_q.line_carry))
		else $error("fill carry changed with fill off");

endmodule

/* dv/blit_word_combiner_unit_test.sv */
module blit_word_combiner_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bwc_pkg::*;

	// The fill selector code that the block treats as no fill.
	localparam logic [1:0] FILL_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1150;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] value;
	} reg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	bwc_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	bwc_out_t    out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_MINTERM;
	logic [15:0] cfg_data = '0;

	bwc_in_t    word_backlog[$];
	reg_write_t reg_backlog[$];
	bwc_out_t   dest_expected[$];

	// Register and line state as the block should hold them.
	bwc_cfg_t   regs_now = '{8'h00, 4'h0, 4'h0, 16'hFFFF, 16'hFFFF, FILL_NONE, 1'b0, 1'b0};
	bwc_state_t line_state = '{16'h0000, 16'h0000, 1'b0, 1'b1};

	bit steady = 1'b0;
	int words_queued = 0;
	int words_checked = 0;
	int settings_applied = 0;
	int lines_made = 0;
	int fail_count = 0;
	int cycle_count = 0;

	blit_word_combiner_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Funnel shift of the current word with the previous word of the same source.
	function automatic logic [15:0] funnel(input logic [15:0] prev, input logic [15:0] cur,
		input logic [3:0] amount, input logic desc);
		logic [31:0] joined;
		if (desc) begin
			joined = {cur, prev} << amount;
			return joined[31:16];
		end
		joined = {prev, cur} >> amount;
		return joined[15:0];
	endfunction

	// Each output bit looks up the truth table at the index {A, B, C}.
	function automatic logic [15:0] apply_minterm(input logic [7:0] truth, input logic [15:0] a,
		input logic [15:0] b, input logic [15:0] c);
		logic [15:0] d;
		for (int i = 0; i < WORD_W; i++)
			d[i] = truth[{a[i], b[i], c[i]}];
		return d;
	endfunction

	// Works out the destination word and zero flag for one accepted word,
	// advancing the line state as it goes.
	function automatic bwc_out_t predict_dest_word(input bwc_in_t w);
		logic [15:0] a_src;
		logic [15:0] sa;
		logic [15:0] sb;
		logic [15:0] d;
		logic        carry;
		logic        bit_in;
		logic        desc;
		int          pos;
		bwc_out_t    r;
		desc = regs_now.reverse_order;
		a_src = w.a_word;
		if (w.blit_begin)
			line_state.zero_flag = 1'b1;
		if (w.line_first) begin
			line_state.prev_a = '0;
			line_state.prev_b = '0;
			line_state.line_carry = regs_now.carry_start;
			a_src &= regs_now.first_mask;
		end
		if (w.line_last)
			a_src &= regs_now.last_mask;
		sa = funnel(line_state.prev_a, a_src, regs_now.a_shift, desc);
		sb = funnel(line_state.prev_b, w.b_word, regs_now.b_shift, desc);
		line_state.prev_a = a_src;
		line_state.prev_b = w.b_word;
		d = apply_minterm(regs_now.minterm, sa, sb, w.c_word);
		// Area fill scans from the top bit down in ascending order, upward otherwise.
		if (regs_now.fill_select == FILL_INCLUSIVE || regs_now.fill_select == FILL_EXCLUSIVE) begin
			carry = line_state.line_carry;
			for (int k = 0; k < WORD_W; k++) begin
				pos = desc ? k : WORD_W - 1 - k;
				bit_in = d[pos];
				d[pos] = (regs_now.fill_select == FILL_INCLUSIVE) ? (carry | bit_in) : (carry ^ bit_in);
				carry ^= bit_in;
			end
			line_state.line_carry = carry;
		end
		if (d != '0)
			line_state.zero_flag = 1'b0;
		r.d_word = d;
		r.all_zero = line_state.zero_flag;
		return r;
	endfunction

	function automatic void add_word(input logic [15:0] a, input logic [15:0] b,
		input logic [15:0] c, input logic first, input logic last, input logic opens_blit);
		bwc_in_t w;
		w.a_word = a;
		w.b_word = b;
		w.c_word = c;
		w.line_first = first;
		w.line_last = last;
		w.blit_begin = opens_blit;
		word_backlog.push_back(w);
		words_queued++;
	endfunction

	function automatic void set_regs(input logic [7:0] mt, input logic [3:0] sa,
		input logic [3:0] sb, input logic [15:0] fm, input logic [15:0] lm,
		input logic [1:0] fs, input logic rev, input logic cs);
		reg_backlog.push_back('{REG_MINTERM, {8'h00, mt}});
		reg_backlog.push_back('{REG_A_SHIFT, {12'h000, sa}});
		reg_backlog.push_back('{REG_B_SHIFT, {12'h000, sb}});
		reg_backlog.push_back('{REG_FIRST_MASK, fm});
		reg_backlog.push_back('{REG_LAST_MASK, lm});
		reg_backlog.push_back('{REG_FILL_SELECT, {14'h0000, fs}});
		reg_backlog.push_back('{REG_REVERSE_ORDER, {15'h0000, rev}});
		reg_backlog.push_back('{REG_CARRY_START, {15'h0000, cs}});
		settings_applied++;
	endfunction

	// Source words lean toward all zeros and all ones now and then.
	function automatic logic [15:0] rand_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] shift_pick();
		case ($urandom_range(3))
			0: return 4'd0;
			1: return 4'd15;
			default: return 4'($urandom);
		endcase
	endfunction

	// Waits until no word, register write or result is outstanding.
	task automatic settle();
		do
			@(negedge clk);
		while (word_backlog.size() != 0 || in_valid || reg_backlog.size() != 0 || cfg_valid
			|| dest_expected.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Word driver: loads the next pending word and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				dest_expected.push_back(predict_dest_word(in_data));
			if (!in_valid || in_ready) begin
				if (word_backlog.size() != 0 && (steady || $urandom_range(99) >= 22)) begin
					in_valid <= 1'b1;
					in_data <= word_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Register write driver: mirrors each accepted write into the expected settings.
	always @(posedge clk or negedge arst_n) begin : reg_drive
		reg_write_t next_write;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MINTERM:       regs_now.minterm = cfg_data[7:0];
					REG_A_SHIFT:       regs_now.a_shift = cfg_data[3:0];
					REG_B_SHIFT:       regs_now.b_shift = cfg_data[3:0];
					REG_FIRST_MASK:    regs_now.first_mask = cfg_data;
					REG_LAST_MASK:     regs_now.last_mask = cfg_data;
					REG_FILL_SELECT:   regs_now.fill_select = cfg_data[1:0];
					REG_REVERSE_ORDER: regs_now.reverse_order = cfg_data[0];
					REG_CARRY_START:   regs_now.carry_start = cfg_data[0];
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_backlog.size() != 0) begin
					next_write = reg_backlog.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= next_write.index;
					cfg_data <= next_write.value;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares every accepted destination word with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : dest_check
		bwc_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (dest_expected.size() == 0) begin
					$error("unexpected destination word: d_word %h all_zero %b",
						out_data.d_word, out_data.all_zero);
					fail_count++;
				end else begin
					want = dest_expected.pop_front();
					words_checked++;
					if (out_data.d_word !== want.d_word) begin
						$error("d_word expected %h actual %h", want.d_word, out_data.d_word);
						fail_count++;
					end
					if (out_data.all_zero !== want.all_zero) begin
						$error("all_zero expected %b actual %b", want.all_zero, out_data.all_zero);
						fail_count++;
					end
				end
			end
			out_ready <= steady || $urandom_range(99) >= 22;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding.",
				cycle_count, dest_expected.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int phase_no;
		int phase_words;
		int target;
		int line_len;
		bit new_blit;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Masks on a one-word line, a full line, a word past the line end,
		// and a blit start that does not open a line.
		set_regs(8'hF0, 4'd4, 4'd0, 16'hFF00, 16'h00FF, FILL_NONE, 1'b0, 1'b0);
		settle();
		add_word(16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
		add_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		add_word(16'h1234, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		add_word(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0);
		add_word(16'hABCD, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b0);
		add_word(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
		settle();

		// Descending B shift with inclusive fill and a preset carry.
		set_regs(8'hCC, 4'd0, 4'd15, 16'hFFFF, 16'hFFFF, FILL_INCLUSIVE, 1'b1, 1'b1);
		settle();
		add_word(16'h0000, 16'h8001, 16'h0000, 1'b1, 1'b0, 1'b1);
		add_word(16'h0000, 16'h0100, 16'h0000, 1'b0, 1'b0, 1'b0);
		add_word(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b0);
		settle();

		// Exclusive fill on C with the masks cleared.
		set_regs(8'hAA, 4'd15, 4'd0, 16'h0000, 16'h0000, FILL_EXCLUSIVE, 1'b0, 1'b0);
		settle();
		add_word(16'hFFFF, 16'h0000, 16'h8421, 1'b1, 1'b0, 1'b1);
		add_word(16'h0000, 16'h0000, 16'h0010, 1'b0, 1'b0, 1'b0);
		add_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
		settle();

		// The unused fill code must leave the carry loaded at line start alone.
		set_regs(8'h96, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, FILL_UNUSED, 1'b1, 1'b1);
		settle();
		add_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		add_word(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
		add_word(16'h8000, 16'h0001, 16'h7FFE, 1'b0, 1'b0, 1'b0);
		settle();

		// With an all-zero minterm the inclusive fill shows that carry directly.
		set_regs(8'h00, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, FILL_INCLUSIVE, 1'b0, 1'b0);
		settle();
		add_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		add_word(16'h0001, 16'h0002, 16'h0003, 1'b1, 1'b1, 1'b0);
		settle();

		// Random phases: mostly well-formed lines grouped into blits, some stray words.
		phase_no = 0;
		while (words_queued < RANDOM_WORDS) begin
			case ($urandom_range(5))
				0: set_regs(8'h00, shift_pick(), shift_pick(), rand_word(), rand_word(),
					2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
				1: set_regs(8'hFF, shift_pick(), shift_pick(), rand_word(), rand_word(),
					2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
				default: set_regs(8'($urandom), shift_pick(), shift_pick(), rand_word(),
					rand_word(), 2'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			endcase
			settle();
			steady = (phase_no == 4);
			target = 50 + $urandom_range(50);
			phase_words = 0;
			while (phase_words < target) begin
				if ($urandom_range(9) == 0) begin
					add_word(rand_word(), rand_word(), rand_word(), 1'($urandom_range(1)),
						1'($urandom_range(1)), 1'($urandom_range(1)));
					phase_words++;
				end else begin
					line_len = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
					new_blit = ($urandom_range(3) == 0);
					for (int k = 0; k < line_len; k++)
						add_word(rand_word(), rand_word(), rand_word(), k == 0, k == line_len - 1,
							new_blit && k == 0);
					phase_words += line_len;
					lines_made++;
				end
			end
			settle();
			steady = 1'b0;
			phase_no++;
		end

		repeat (8) @(negedge clk);
		$display("Checked %0d destination words over %0d register settings and %0d random lines,",
			words_checked, settings_applied, lines_made);
		$display("covering both shift orders, all fill codes and blit starts inside lines.");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
design/bwc_pkg.sv
design/bwc_word_logic.sv
design/blit_word_combiner_unit.sv
dv/blit_word_combiner_unit_test.sv
